// ===== src/svwm_pkg.sv =====
// shared types and constants for the supply voltage window monitor
`timescale 1ns / 1ps

package svwm_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_PU    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RVP_OFF_COMP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VOLTAGE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLTAGE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HYST_LOW     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HYST_HIGH    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_EVENT_LIMIT  = 3'd7;

	// reset values
	localparam logic [15:0] GAIN_RST        = 16'd32768;
	localparam logic [15:0] OFFSET_PU_RST   = 16'd0;
	localparam logic [15:0] RVP_COMP_RST    = 16'd0;
	localparam logic [15:0] MIN_VOLTAGE_RST = 16'd0;
	localparam logic [15:0] MAX_VOLTAGE_RST = 16'hFFFF;
	localparam logic [15:0] HYST_LOW_RST    = 16'd0;
	localparam logic [15:0] HYST_HIGH_RST   = 16'd0;
	localparam logic [7:0]  EVENT_LIMIT_RST = 8'd8;

	localparam int CONV_W      = 8;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		DIAG_OK    = 2'd0,
		DIAG_UNDER = 2'd1,
		DIAG_OVER  = 2'd2
	} diag_t;

	// one scaled item between front and back
	typedef struct packed {
		logic [15:0] volt_base;
		logic        rvp_on;
		logic        check_tick;
	} q_entry_t;

	// window and debounce settings used by the back end
	typedef struct packed {
		logic [15:0] rvp_off_comp;
		logic [15:0] min_voltage;
		logic [15:0] max_voltage;
		logic [15:0] hyst_low;
		logic [15:0] hyst_high;
		logic [7:0]  event_limit;
	} window_cfg_t;

	// front end status toward the top level
	typedef struct packed {
		logic busy;
		logic push;
	} front_status_t;

endpackage

// ===== src/supply_voltage_window_monitor.sv =====
// top level of the supply voltage window monitor
`timescale 1ns / 1ps
// usage:
// - input channel (in_valid / in_stall) carries one raw converter sample with
//   the reverse protection flag and the check tick; one transfer per sample
// - output channel (out_valid / out_stall) returns one result per sample:
//   latched fault, diagnostic code and compensated per-unit voltage
// - config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the
//   eight settings registers; cfg_ready is always high, unknown data bits
//   above a register's width are dropped; write only while the block is idle
// - from input transfer to out_valid, the sample times gain product is
//   registered in the front stage, the conversion multiply and offset are
//   written into the queue, then the window test into the result register;
//   a full queue or a stalling receiver can hold each step
// - one item per cycle is sustained while the receiver does not stall; the rate
//   is set by the result register, refilled in the cycle the previous result leaves
// - when the receiver stalls, the result holds, the two-entry queue fills,
//   then the front stage holds and in_stall rises
// - reset empties the queue and result register, drops the fault, loads the
//   event counter with the reset event limit and the registers with defaults

module supply_voltage_window_monitor import svwm_pkg::*; #(
	parameter int SCALE_SHIFT = 15,
	parameter int CONV_FACTOR = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [15:0]          adc_sample,
	input  logic                 rvp_on,
	input  logic                 check_tick,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 fault,
	output logic [1:0]           diag_code,
	output logic [15:0]          voltage_pu,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	// settings registers
	logic [15:0] gain_q;
	logic [15:0] offset_pu_q;
	logic [15:0] rvp_off_comp_q;
	logic [15:0] min_voltage_q;
	logic [15:0] max_voltage_q;
	logic [15:0] hyst_low_q;
	logic [15:0] hyst_high_q;
	logic [7:0]  event_limit_q;

	// front to queue to back
	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	q_entry_t      wr_entry;
	q_entry_t      rd_entry;
	front_status_t front_st;
	window_cfg_t   wcfg;

	assign cfg_ready = 1'b1;

	// register file write, one register per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q         <= GAIN_RST;
			offset_pu_q    <= OFFSET_PU_RST;
			rvp_off_comp_q <= RVP_COMP_RST;
			min_voltage_q  <= MIN_VOLTAGE_RST;
			max_voltage_q  <= MAX_VOLTAGE_RST;
			hyst_low_q     <= HYST_LOW_RST;
			hyst_high_q    <= HYST_HIGH_RST;
			event_limit_q  <= EVENT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN:         gain_q         <= cfg_data;
				REG_OFFSET_PU:    offset_pu_q    <= cfg_data;
				REG_RVP_OFF_COMP: rvp_off_comp_q <= cfg_data;
				REG_MIN_VOLTAGE:  min_voltage_q  <= cfg_data;
				REG_MAX_VOLTAGE:  max_voltage_q  <= cfg_data;
				REG_HYST_LOW:     hyst_low_q     <= cfg_data;
				REG_HYST_HIGH:    hyst_high_q    <= cfg_data;
				REG_EVENT_LIMIT:  event_limit_q  <= cfg_data[7:0];
				default:          gain_q         <= gain_q;
			endcase
		end
	end

	// back end settings travel as one group
	assign wcfg.rvp_off_comp = rvp_off_comp_q;
	assign wcfg.min_voltage  = min_voltage_q;
	assign wcfg.max_voltage  = max_voltage_q;
	assign wcfg.hyst_low     = hyst_low_q;
	assign wcfg.hyst_high    = hyst_high_q;
	assign wcfg.event_limit  = event_limit_q;

	// front end: gain multiply, shift, conversion and offset
	svwm_front #(
		.SCALE_SHIFT (SCALE_SHIFT),
		.CONV_FACTOR (CONV_FACTOR)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.adc_sample (adc_sample),
		.rvp_on     (rvp_on),
		.check_tick (check_tick),
		.gain       (gain_q),
		.offset_pu  (offset_pu_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (wr_entry),
		.status     (front_st)
	);

	// decoupling queue, lets the front keep taking samples during a stall
	svwm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (wr_entry),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_entry (rd_entry)
	);

	// back end: compensation, window with hysteresis, debounce counter
	svwm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_entry    (rd_entry),
		.q_pop      (q_pop),
		.wcfg       (wcfg),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.fault      (fault),
		.diag_code  (diag_code),
		.voltage_pu (voltage_pu)
	);

	// queue never written while full
	assert property (@(posedge clk) disable iff (!arst_n) !(q_push && q_full))
		else $error("queue push while full");

	// queue never read while empty
	assert property (@(posedge clk) disable iff (!arst_n) !(q_pop && !q_valid))
		else $error("queue pop while empty");

	// the input side only stalls while the front stage holds a sample it cannot push
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (front_st.busy && !front_st.push))
		else $error("input stalled without a blocked front item");

endmodule

// ===== src/svwm_front.sv =====
// front end: accepts samples, scales them and pushes them into the queue
`timescale 1ns / 1ps

module svwm_front import svwm_pkg::*; #(
	parameter int SCALE_SHIFT = 15,
	parameter int CONV_FACTOR = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [15:0]   adc_sample,
	input  logic          rvp_on,
	input  logic          check_tick,
	input  logic [15:0]   gain,
	input  logic [15:0]   offset_pu,
	input  logic          q_full,
	output logic          q_push,
	output q_entry_t      q_entry,
	output front_status_t status
);

	localparam logic [CONV_W-1:0] CONV = CONV_W'(CONV_FACTOR);

	logic        valid_s1;
	logic [31:0] prod_s1;
	logic        rvp_s1;
	logic        tick_s1;
	logic        accept;
	logic [31:0] shifted;
	logic [15:0] scaled;
	logic [23:0] conv_prod;

	assign q_push   = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// raw product registered before the conversion multiply
	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1 <= 32'(adc_sample) * 32'(gain);
			rvp_s1  <= rvp_on;
			tick_s1 <= check_tick;
		end
	end

	always_comb begin
		shifted              = prod_s1 >> SCALE_SHIFT;
		scaled               = shifted[15:0];
		conv_prod            = 24'(scaled) * 24'(CONV);
		q_entry.volt_base    = conv_prod[15:0] + offset_pu;
		q_entry.rvp_on       = rvp_s1;
		q_entry.check_tick   = tick_s1;
	end

	assign status.busy = valid_s1;
	assign status.push = q_push;

endmodule

// ===== src/svwm_queue.sv =====
// short queue between the front and back ends
`timescale 1ns / 1ps

module svwm_queue import svwm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t wr_entry,
	output logic     full,
	input  logic     pop,
	output logic     rd_valid,
	output q_entry_t rd_entry
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	q_entry_t         slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == FULL_CNT);
	assign rd_valid = (cnt_q != '0);
	assign rd_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

// ===== src/svwm_back.sv =====
// back end: compensation, window test, event debounce and result register
`timescale 1ns / 1ps

module svwm_back import svwm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  q_entry_t    q_entry,
	output logic        q_pop,
	input  window_cfg_t wcfg,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        fault,
	output logic [1:0]  diag_code,
	output logic [15:0] voltage_pu
);

	logic        out_valid_q;
	logic        fault_q;
	logic [7:0]  cnt_q;
	diag_t       diag_q;
	logic [15:0] volt_q;

	logic [15:0] volt;
	logic [15:0] lo;
	logic [15:0] hi;
	diag_t       diag;
	logic [7:0]  cnt_tick;
	logic [7:0]  cnt_next;
	logic        fault_next;

	// take the next item whenever the result register is free or emptying
	assign q_pop = q_valid && (!out_valid_q || !out_stall);

	always_comb begin
		volt = q_entry.volt_base + (q_entry.rvp_on ? 16'd0 : wcfg.rvp_off_comp);
		lo   = fault_q ? wcfg.min_voltage + wcfg.hyst_low : wcfg.min_voltage;
		hi   = fault_q ? wcfg.max_voltage - wcfg.hyst_high : wcfg.max_voltage;
		priority if (volt <= lo) begin
			diag = DIAG_UNDER;
		end else if (volt >= hi) begin
			diag = DIAG_OVER;
		end else begin
			diag = DIAG_OK;
		end
	end

	always_comb begin
		cnt_tick = cnt_q;
		if (q_entry.check_tick) begin
			if (diag == DIAG_OK) begin
				cnt_tick = '0;
			end else if (cnt_q != 8'hFF) begin
				cnt_tick = cnt_q + 8'd1;
			end
		end
		if (cnt_tick >= wcfg.event_limit) begin
			cnt_next   = wcfg.event_limit;
			fault_next = 1'b1;
		end else begin
			cnt_next   = cnt_tick;
			fault_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			fault_q     <= 1'b0;
			cnt_q       <= EVENT_LIMIT_RST;
		end else begin
			if (q_pop) begin
				out_valid_q <= 1'b1;
				fault_q     <= fault_next;
				cnt_q       <= cnt_next;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			diag_q <= diag;
			volt_q <= volt;
		end
	end

	assign out_valid  = out_valid_q;
	assign fault      = fault_q;
	assign diag_code  = diag_q;
	assign voltage_pu = volt_q;

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for the supply voltage window monitor
`timescale 1ns / 1ps

module testbench;
	import svwm_pkg::*;

	// must match the block's build parameters
	localparam int SHIFT_BITS = 15;
	localparam int CONV_MULT  = 1;

	// one raw converter sample as the sender offers it
	typedef struct packed {
		logic [15:0] raw;
		logic        rvp;
		logic        tick;
	} supply_item_t;

	// one predicted result
	typedef struct packed {
		logic        fault;
		diag_t       diag;
		logic [15:0] volt;
	} window_result_t;

	// how a run of samples is aimed at the window
	typedef enum logic [1:0] {
		RUN_OUTSIDE,
		RUN_INSIDE,
		RUN_EDGE,
		RUN_NOISE
	} run_kind_t;

	logic                 clk;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_stall;
	logic [15:0]          adc_sample = '0;
	logic                 rvp_on     = 1'b0;
	logic                 check_tick = 1'b0;
	logic                 out_valid;
	logic                 out_stall  = 1'b0;
	logic                 fault;
	logic [1:0]           diag_code;
	logic [15:0]          voltage_pu;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index  = REG_GAIN;
	logic [15:0]          cfg_data   = '0;

	// copy of the settings registers, follows every config transfer
	logic [15:0] set_gain    = GAIN_RST;
	logic [15:0] set_offset  = OFFSET_PU_RST;
	logic [15:0] set_comp    = RVP_COMP_RST;
	logic [15:0] set_vmin    = MIN_VOLTAGE_RST;
	logic [15:0] set_vmax    = MAX_VOLTAGE_RST;
	logic [15:0] set_hyst_lo = HYST_LOW_RST;
	logic [15:0] set_hyst_hi = HYST_HIGH_RST;
	logic [7:0]  set_limit   = EVENT_LIMIT_RST;

	// debounce state as the block should hold it
	logic [7:0] debounce_count = EVENT_LIMIT_RST;
	logic       fault_state    = 1'b0;

	supply_item_t   pending_samples[$];
	window_result_t expected_results[$];

	int queued_total   = 0;
	int accepted_total = 0;
	int results_total  = 0;
	int cfg_writes     = 0;
	int mismatches     = 0;

	// idle shaping, changed per phase
	int   sender_idle_pct    = 0;
	int   receiver_stall_pct = 0;
	logic calm               = 1'b0;
	logic hold_off           = 1'b0;
	int   send_gap           = 0;
	int   stall_gap          = 0;

	supply_voltage_window_monitor #(
		.SCALE_SHIFT(SHIFT_BITS),
		.CONV_FACTOR(CONV_MULT)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.adc_sample(adc_sample),
		.rvp_on    (rvp_on),
		.check_tick(check_tick),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.fault     (fault),
		.diag_code (diag_code),
		.voltage_pu(voltage_pu),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// scale, compensate, test against the (possibly narrowed) window,
	// then advance the debounce counter and the latched fault
	function automatic window_result_t predict_window_result(input logic [15:0] raw,
			input logic rvp, input logic tick);
		logic [31:0]    prod;
		logic [31:0]    wide;
		logic [15:0]    scaled;
		logic [15:0]    volt;
		logic [15:0]    lo;
		logic [15:0]    hi;
		window_result_t r;
		prod   = {16'd0, raw} * {16'd0, set_gain};
		wide   = prod >> SHIFT_BITS;
		scaled = wide[15:0];
		wide   = 32'(scaled) * 32'(CONV_MULT) + 32'(set_offset);
		volt   = wide[15:0];
		// compensation only while reverse protection is off, wraps at 16 bits
		if (!rvp) begin
			volt = volt + set_comp;
		end
		lo = set_vmin;
		hi = set_vmax;
		// latched fault narrows the window, both bounds wrap
		if (fault_state) begin
			lo = set_vmin + set_hyst_lo;
			hi = set_vmax - set_hyst_hi;
		end
		// lower test first, so meeting both bounds reads as undervoltage
		if (volt <= lo) begin
			r.diag = DIAG_UNDER;
		end else if (volt >= hi) begin
			r.diag = DIAG_OVER;
		end else begin
			r.diag = DIAG_OK;
		end
		if (tick) begin
			if (r.diag != DIAG_OK) begin
				// saturate instead of wrapping
				if (debounce_count != 8'd255) begin
					debounce_count = debounce_count + 8'd1;
				end
			end else begin
				debounce_count = 8'd0;
			end
		end
		// re-evaluated on every sample, clamps after a limit change too
		if (debounce_count >= set_limit) begin
			debounce_count = set_limit;
			fault_state    = 1'b1;
		end else begin
			fault_state = 1'b0;
		end
		r.fault = fault_state;
		r.volt  = volt;
		return r;
	endfunction

	// track settings from the config transfers themselves
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN:         set_gain    <= cfg_data;
				REG_OFFSET_PU:    set_offset  <= cfg_data;
				REG_RVP_OFF_COMP: set_comp    <= cfg_data;
				REG_MIN_VOLTAGE:  set_vmin    <= cfg_data;
				REG_MAX_VOLTAGE:  set_vmax    <= cfg_data;
				REG_HYST_LOW:     set_hyst_lo <= cfg_data;
				REG_HYST_HIGH:    set_hyst_hi <= cfg_data;
				REG_EVENT_LIMIT:  set_limit   <= cfg_data[7:0];
				default: ;
			endcase
			cfg_writes <= cfg_writes + 1;
		end
	end

	// sender: predicts on every input transfer, then offers the next sample
	// unless an idle burst is running; a stalled offer is left untouched
	always @(posedge clk) begin : feed_samples
		supply_item_t nxt;
		if (in_valid && !in_stall) begin
			expected_results.push_back(predict_window_result(adc_sample, rvp_on, check_tick));
			accepted_total++;
		end
		if (!(in_valid && in_stall)) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_samples.size() == 0) begin
				in_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < sender_idle_pct) begin
				send_gap <= $urandom_range(0, 4);
				in_valid <= 1'b0;
			end else begin
				nxt        = pending_samples.pop_front();
				adc_sample <= nxt.raw;
				rvp_on     <= nxt.rvp;
				check_tick <= nxt.tick;
				in_valid   <= 1'b1;
			end
		end
	end

	// receiver: checks each output transfer against the oldest prediction
	always @(posedge clk) begin : check_results
		window_result_t want;
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: fault=%0d diag=%0d volt=%0d",
						fault, diag_code, voltage_pu);
				end
			end else begin
				want = expected_results.pop_front();
				results_total++;
				if (fault !== want.fault || diag_code !== want.diag ||
						voltage_pu !== want.volt) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch on result %0d: expected fault=%0d diag=%0d volt=%0d",
							results_total, want.fault, want.diag, want.volt);
						$display("  got fault=%0d diag=%0d volt=%0d",
							fault, diag_code, voltage_pu);
					end
				end
			end
		end
		// long hold-off wins over the short random bursts
		if (hold_off) begin
			out_stall <= 1'b1;
		end else if (stall_gap != 0) begin
			stall_gap <= stall_gap - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 99) < receiver_stall_pct) begin
			stall_gap <= $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// back-pressure: receiver holds off long enough for the queue to fill
	// and the input to stall, while plenty of samples are still waiting
	initial begin
		wait (accepted_total > 300 && queued_total - accepted_total > 60);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (80) @(posedge clk);
		hold_off <= 1'b0;
		wait (accepted_total > 1000 && queued_total - accepted_total > 60);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (80) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic push_item(input logic [15:0] raw, input logic rvp, input logic tick);
		supply_item_t it;
		it.raw  = raw;
		it.rvp  = rvp;
		it.tick = tick;
		pending_samples.push_back(it);
		queued_total++;
	endtask

	// one config transfer; valid stays up so back-to-back writes are one per cycle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		int n;
		n = cfg_writes;
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		wait (cfg_writes != n);
	endtask

	task automatic load_settings(input logic [15:0] g, input logic [15:0] off,
			input logic [15:0] comp, input logic [15:0] vmin, input logic [15:0] vmax,
			input logic [15:0] hl, input logic [15:0] hh, input logic [15:0] lim_word);
		@(posedge clk);
		write_reg(REG_GAIN, g);
		write_reg(REG_OFFSET_PU, off);
		write_reg(REG_RVP_OFF_COMP, comp);
		write_reg(REG_MIN_VOLTAGE, vmin);
		write_reg(REG_MAX_VOLTAGE, vmax);
		write_reg(REG_HYST_LOW, hl);
		write_reg(REG_HYST_HIGH, hh);
		write_reg(REG_EVENT_LIMIT, lim_word);
		cfg_valid <= 1'b0;
	endtask

	// block idle: all results back plus the pipeline depth
	task automatic drain;
		wait (results_total == queued_total);
		repeat (4) @(posedge clk);
	endtask

	// rough inverse of the scaling, lands a sample near a wanted voltage
	function automatic logic [15:0] sample_for(input logic [15:0] volt, input logic rvp);
		logic [15:0] base;
		logic [63:0] s;
		base = volt - set_offset;
		if (!rvp) begin
			base = base - set_comp;
		end
		if (set_gain == 16'd0) begin
			return 16'($urandom);
		end
		s = 64'(base);
		s = s / 64'(CONV_MULT);
		s = s << SHIFT_BITS;
		s = (s + 64'(set_gain) - 64'd1) / 64'(set_gain);
		if (s > 64'd65535) begin
			return 16'hFFFF;
		end
		return s[15:0];
	endfunction

	function automatic logic [15:0] pick_volt(input run_kind_t kind);
		logic [15:0] v;
		int          j;
		int          lo_i;
		int          hi_i;
		j    = $urandom_range(0, 4);
		j    = j - 2;
		lo_i = int'(set_vmin);
		hi_i = int'(set_vmax);
		case (kind)
			RUN_OUTSIDE: begin
				if ($urandom_range(0, 1)) begin
					v = 16'($urandom_range(0, lo_i));
				end else begin
					v = 16'($urandom_range(hi_i, 65535));
				end
			end
			RUN_INSIDE: begin
				if (hi_i - lo_i > 2) begin
					v = 16'($urandom_range(lo_i + 1, hi_i - 1));
				end else begin
					v = 16'($urandom);
				end
			end
			default: begin
				// plain and hysteresis bounds, give or take two
				case ($urandom_range(0, 3))
					0: v = 16'(lo_i + j);
					1: v = 16'(hi_i + j);
					2: v = 16'(lo_i + int'(set_hyst_lo) + j);
					default: v = 16'(hi_i - int'(set_hyst_hi) + j);
				endcase
			end
		endcase
		return v;
	endfunction

	// runs of out-of-window samples, some long enough to trip the debounce,
	// in-window runs to clear it, samples on the bounds, and some noise
	task automatic queue_phase(input int n);
		int        left;
		int        run;
		int        k;
		run_kind_t kind;
		logic      rv;
		left = n;
		while (left > 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: kind = RUN_OUTSIDE;
				4, 5, 6:    kind = RUN_INSIDE;
				7, 8:       kind = RUN_EDGE;
				default:    kind = RUN_NOISE;
			endcase
			if (kind == RUN_OUTSIDE) begin
				if ($urandom_range(0, 1)) begin
					run = int'(set_limit) + int'($urandom_range(1, 3));
				end else begin
					run = int'($urandom_range(1, int'(set_limit) + 2));
				end
			end else begin
				run = $urandom_range(1, 6);
			end
			if (run > left) begin
				run = left;
			end
			for (k = 0; k < run; k++) begin
				rv = 1'($urandom_range(0, 1));
				if (kind == RUN_NOISE) begin
					push_item(16'($urandom), rv, 1'($urandom_range(0, 1)));
				end else begin
					push_item(sample_for(pick_volt(kind), rv), rv, $urandom_range(0, 9) < 8);
				end
				left--;
			end
		end
	endtask

	task automatic draw_settings(input int p);
		logic [15:0] g;
		logic [15:0] off;
		logic [15:0] comp;
		logic [15:0] vmin;
		logic [15:0] vmax;
		logic [15:0] hl;
		logic [15:0] hh;
		logic [15:0] t;
		logic [7:0]  lim;
		logic [7:0]  junk;
		int          c;
		int          w;
		case ($urandom_range(0, 4))
			0: g = 16'd32768;
			1: g = 16'hFFFF;
			2: g = 16'($urandom_range(0, 3));
			3: g = 16'($urandom_range(16384, 49152));
			default: g = 16'($urandom);
		endcase
		case ($urandom_range(0, 2))
			0: off = 16'd0;
			1: off = 16'($urandom);
			default: off = 16'($urandom_range(0, 500));
		endcase
		case ($urandom_range(0, 3))
			0: comp = 16'd0;
			1: comp = 16'hFFFF;
			2: comp = 16'($urandom);
			default: comp = 16'($urandom_range(0, 300));
		endcase
		c = $urandom_range(0, 65535);
		w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40000) : $urandom_range(0, 3000);
		vmin = (c - w < 0) ? 16'd0 : 16'(c - w);
		vmax = (c + w > 65535) ? 16'hFFFF : 16'(c + w);
		case ($urandom_range(0, 7))
			0: begin
				// inverted window, nothing is inside
				t    = vmin;
				vmin = vmax;
				vmax = t;
			end
			1: vmax = vmin;
			2: begin
				vmin = 16'd0;
				vmax = 16'hFFFF;
			end
			default: ;
		endcase
		case ($urandom_range(0, 2))
			0: hl = 16'd0;
			1: hl = 16'($urandom_range(0, 300));
			default: hl = 16'($urandom);
		endcase
		case ($urandom_range(0, 2))
			0: hh = 16'd0;
			1: hh = 16'($urandom_range(0, 300));
			default: hh = 16'($urandom);
		endcase
		case ($urandom_range(0, 15))
			0: lim = 8'd0;
			1: lim = 8'd255;
			2: lim = 8'd1;
			default: lim = 8'($urandom_range(2, 12));
		endcase
		// two fixed corners: everything at the top, everything at the bottom but a limit of one
		if (p == 1) begin
			g    = 16'hFFFF;
			off  = 16'hFFFF;
			comp = 16'hFFFF;
			vmin = 16'hFFFF;
			vmax = 16'hFFFF;
			hl   = 16'hFFFF;
			hh   = 16'hFFFF;
			lim  = 8'd255;
		end else if (p == 2) begin
			g    = 16'd0;
			off  = 16'd0;
			comp = 16'd0;
			vmin = 16'd0;
			vmax = 16'd0;
			hl   = 16'd0;
			hh   = 16'd0;
			lim  = 8'd1;
		end
		// upper byte of the limit word is dropped by the block
		junk = 8'($urandom);
		load_settings(g, off, comp, vmin, vmax, hl, hh, {junk, lim});
	endtask

	initial begin : stimulus
		int p;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: unit gain, full window, count already at the limit
		push_item(16'd0, 1'b1, 1'b0);
		push_item(16'hFFFF, 1'b1, 1'b1);
		push_item(16'd1000, 1'b0, 1'b1);
		push_item(16'd1000, 1'b1, 1'b0);
		drain();

		// equal bounds, wrapping compensation and hysteresis, limit of two
		load_settings(16'd32768, 16'd100, 16'hFFFF, 16'd1000, 16'd1000,
			16'd65000, 16'd2000, 16'hA502);
		push_item(16'd900, 1'b1, 1'b1);
		push_item(16'd900, 1'b1, 1'b1);
		push_item(16'd400, 1'b1, 1'b1);
		push_item(16'hFFFF, 1'b0, 1'b1);
		push_item(16'hFFFF, 1'b1, 1'b0);
		push_item(16'd0, 1'b0, 1'b1);
		push_item(16'd64436, 1'b1, 1'b1);
		push_item(16'd30000, 1'b1, 1'b1);
		push_item(16'd30000, 1'b0, 1'b0);
		push_item(16'd899, 1'b1, 1'b1);
		push_item(16'd901, 1'b1, 1'b1);
		drain();

		// zero event limit: fault always set, count held at zero
		load_settings(16'hFFFF, 16'd0, 16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'h5A00);
		push_item(16'd0, 1'b0, 1'b1);
		push_item(16'hFFFF, 1'b1, 1'b1);
		push_item(16'd12345, 1'b0, 1'b0);
		drain();

		// random phases, idling varies, the last phase runs flat out
		for (p = 0; p < 10; p++) begin
			case ($urandom_range(0, 2))
				0: sender_idle_pct = 0;
				1: sender_idle_pct = 15;
				default: sender_idle_pct = 40;
			endcase
			case ($urandom_range(0, 2))
				0: receiver_stall_pct = 0;
				1: receiver_stall_pct = 15;
				default: receiver_stall_pct = 40;
			endcase
			calm = (p == 9);
			draw_settings(p);
			queue_phase((set_limit == 8'd255) ? 320 : 185);
			drain();
		end

		repeat (8) @(posedge clk);
		mismatches += expected_results.size();
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
